>>> rtl/implicit_list_heap_allocator_assert.svh
// assertion macros for the heap allocator checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_ASSERT_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ILHA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ILHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ilha_pkg.sv
// shared types, constants and helpers of the implicit-list heap allocator
// no dependencies
`default_nettype none

package ilha_pkg;

  localparam int HEAP_WORDS = 1024;
  localparam int WADDR_W    = $clog2(HEAP_WORDS);
  localparam int CNT_W      = $clog2(HEAP_WORDS + 1);
  localparam int CUR_W      = $clog2(HEAP_WORDS + 2048);
  localparam int STEP_LIM   = 2 * HEAP_WORDS;
  localparam int STEP_W     = $clog2(STEP_LIM + 1);
  localparam int WORD_W     = 13;
  localparam int BYTE_W     = 12;
  localparam int FUNC_W     = 2;
  localparam int TOT_W      = (CNT_W + 2 > WORD_W) ? CNT_W + 2 : WORD_W;

  localparam logic [TOT_W-1:0]  CAP_BYTES      = TOT_W'((HEAP_WORDS * 4) & ~7);
  localparam logic [BYTE_W-1:0] HEAP_BYTES_RST = BYTE_W'(4084);
  localparam logic [CUR_W-1:0]  FIRST_WORD     = CUR_W'(1);

  localparam logic [FUNC_W-1:0] FUNC_ALLOC    = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_FREE     = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_COALESCE = FUNC_W'(2);

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_NO_FIT = 1'b1;

  localparam int HDR_ALLOC_BIT = 0;
  localparam int HDR_MARK_BIT  = 1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] request_length;
    logic [BYTE_W-1:0] block_address;
  } ilha_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] granted_address;
    logic              status;
  } ilha_out_t;

  typedef struct packed {
    logic in_stall;
    logic res_valid;
  } ilha_ctl_t;

  // size field of a header in bytes
  function automatic logic [WORD_W-1:0] hdr_size(input logic [WORD_W-1:0] word);
    return {word[WORD_W-1:3], 3'b000};
  endfunction

  // words in use for a requested heap size, saturated to the memory
  function automatic logic [CNT_W-1:0] used_words_of(input logic [BYTE_W-1:0] hb);
    logic [TOT_W-1:0] total;
    total = (TOT_W'(hb) + TOT_W'(19)) & ~TOT_W'(7);
    if (total > CAP_BYTES) begin
      total = CAP_BYTES;
    end
    return CNT_W'(total >> 2);
  endfunction

endpackage

`default_nettype wire

>>> rtl/implicit_list_heap_allocator.sv
// implicit-list first-fit heap allocator: top level with the result register
// depends on ilha_pkg and ilha_core
//
// usage
// - request channel in_valid_i / in_stall_o / in_i carries func, request_length and
//   block_address; a request is taken when in_valid_i is high and in_stall_o is low
// - result channel out_valid_o / out_stall_i / out_o carries granted_address and
//   status, one result per request
// - cfg_wr_en_i with cfg_wr_data_i sets the heap size in bytes and rebuilds the heap
// - one request at a time; in_stall_o stays high until its result is in the
//   output register
// - allocate: a read and a check per header passed over, one more write to split a block
// - free: a header read and write, none past the heap in use; unused func code: none
// - coalesce: reads the current and the next header per merge or step along the list
// - the single heap read port makes these reads one after another
// - after reset and after each heap size write, the first header and then the
//   sentinel are written while in_stall_o is high
// - a stalled result stays in the output register; the block holds the next result
//   and stalls requests until the register drains
`default_nettype none

module implicit_list_heap_allocator
  import ilha_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ilha_in_t          in_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ilha_out_t              out_o,
  input  wire logic              cfg_wr_en_i,
  input  wire logic [BYTE_W-1:0] cfg_wr_data_i
);

  ilha_ctl_t ctl;
  ilha_out_t res;
  logic      res_take;
  logic      out_valid_q, out_valid_d;
  ilha_out_t out_q;

  ilha_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_i          (in_i),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .res_take_i    (res_take),
    .ctl_o         (ctl),
    .res_o         (res)
  );

  // output slot is free when empty or draining this cycle
  assign res_take = ctl.res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = ctl.in_stall;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> rtl/ilha_core.sv
// heap memory and the sequencer that walks the block list with one step adder
// depends on ilha_pkg
`default_nettype none

module ilha_core
  import ilha_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire ilha_in_t         in_i,
  input  wire logic             cfg_wr_en_i,
  input  wire logic [BYTE_W-1:0] cfg_wr_data_i,
  input  wire logic             res_take_i,
  output ilha_ctl_t             ctl_o,
  output ilha_out_t             res_o
);

  typedef enum logic [3:0] {
    ST_INIT_HDR,
    ST_INIT_END,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_WR,
    ST_F_RD,
    ST_F_WR,
    ST_C_RD,
    ST_C_CUR,
    ST_C_NX,
    ST_RESP
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   used_q, used_d;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic [CUR_W-1:0]   nx_q, nx_d;
  logic [WORD_W-1:0]  hcur_q, hcur_d;
  logic [WORD_W-1:0]  need_q, need_d;
  logic [STEP_W-1:0]  steps_q, steps_d;
  logic [BYTE_W-1:0]  res_addr_q, res_addr_d;
  logic               res_status_q, res_status_d;

  logic [WORD_W-1:0]  mem_q [HEAP_WORDS];
  logic [WORD_W-1:0]  rdata_q;
  logic               mem_we;
  logic [WADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WADDR_W-1:0] mem_raddr;

  logic [CUR_W-1:0]   rd_idx;
  logic [WORD_W-1:0]  rd_hdr;
  logic [WORD_W-1:0]  rd_size;
  logic [CUR_W-1:0]   step_base;
  logic [WORD_W-1:0]  step_bytes;
  logic [CUR_W-1:0]   step_sum;
  logic [WORD_W-1:0]  merge_sum;
  logic [WORD_W-1:0]  init_word;
  logic               fit;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // header just read, zero when its index lies past the heap in use
  always_comb begin
    rd_idx  = (state_q == ST_C_NX) ? nx_q : cur_q;
    rd_hdr  = (rd_idx < CUR_W'(used_q)) ? rdata_q : '0;
    rd_size = hdr_size(rd_hdr);
    fit     = !rd_hdr[HDR_ALLOC_BIT] && (rd_size >= need_q);
  end

  // shared step adder: index plus a size in words
  always_comb begin
    step_base  = cur_q;
    step_bytes = rd_size;
    unique case (state_q)
      ST_A_CHK: step_bytes = fit ? need_q : rd_size;
      ST_C_NX:  step_base  = nx_q;
      default: begin
      end
    endcase
    step_sum = step_base + CUR_W'(step_bytes[WORD_W-1:2]);
  end

  assign merge_sum = hdr_size(hcur_q) + rd_size;
  assign init_word = WORD_W'({used_q, 2'b00} - (CNT_W + 2)'(8));

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    cur_d        = cur_q;
    nx_d         = nx_q;
    hcur_d       = hcur_q;
    need_d       = need_q;
    steps_d      = steps_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_q[WADDR_W-1:0];
    mem_wdata    = '0;
    mem_raddr    = cur_q[WADDR_W-1:0];

    unique case (state_q)
      ST_INIT_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = FIRST_WORD[WADDR_W-1:0];
        mem_wdata = init_word;
        state_d   = ST_INIT_END;
      end
      ST_INIT_END: begin
        // sentinel in the last word in use
        mem_we    = 1'b1;
        mem_waddr = WADDR_W'(used_q - CNT_W'(1));
        mem_wdata = '0;
        state_d   = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          res_addr_d   = '0;
          res_status_d = STATUS_DONE;
          steps_d      = '0;
          cur_d        = FIRST_WORD;
          unique case (in_i.func)
            FUNC_ALLOC: begin
              need_d  = (WORD_W'(in_i.request_length) + WORD_W'(11)) & ~WORD_W'(7);
              state_d = ST_A_RD;
            end
            FUNC_FREE: begin
              cur_d   = CUR_W'(in_i.block_address[BYTE_W-1:2]);
              state_d = ST_F_RD;
            end
            FUNC_COALESCE: state_d = ST_C_RD;
            default:       state_d = ST_RESP;
          endcase
        end
      end
      ST_A_RD: begin
        if (steps_q == STEP_W'(STEP_LIM)) begin
          res_status_d = STATUS_NO_FIT;
          state_d      = ST_RESP;
        end else begin
          state_d = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (rd_size == '0) begin
          res_status_d = STATUS_NO_FIT;
          state_d      = ST_RESP;
        end else if (fit) begin
          res_addr_d = BYTE_W'({cur_q, 2'b00});
          if (rd_size != need_q) begin
            // split: remainder header first, then the taken block
            mem_we    = step_sum < CUR_W'(used_q);
            mem_waddr = step_sum[WADDR_W-1:0];
            mem_wdata = rd_size - need_q;
            state_d   = ST_A_WR;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = need_q | WORD_W'(1);
            state_d   = ST_RESP;
          end
        end else begin
          cur_d   = step_sum;
          steps_d = steps_q + STEP_W'(1);
          state_d = ST_A_RD;
        end
      end
      ST_A_WR: begin
        mem_we    = 1'b1;
        mem_wdata = need_q | WORD_W'(1);
        state_d   = ST_RESP;
      end
      ST_F_RD: begin
        state_d = (cur_q < CUR_W'(used_q)) ? ST_F_WR : ST_RESP;
      end
      ST_F_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {rdata_q[WORD_W-1:2], 2'b00};
        state_d   = ST_RESP;
      end
      ST_C_RD: begin
        state_d = (steps_q == STEP_W'(STEP_LIM)) ? ST_RESP : ST_C_CUR;
      end
      ST_C_CUR: begin
        if (rd_size == '0) begin
          state_d = ST_RESP;
        end else begin
          hcur_d    = rd_hdr;
          nx_d      = step_sum;
          mem_raddr = step_sum[WADDR_W-1:0];
          state_d   = ST_C_NX;
        end
      end
      ST_C_NX: begin
        if (rd_size == '0) begin
          state_d = ST_RESP;
        end else begin
          steps_d = steps_q + STEP_W'(1);
          state_d = ST_C_RD;
          if (hcur_q[HDR_ALLOC_BIT]) begin
            cur_d = nx_q;
          end else if (!rd_hdr[HDR_ALLOC_BIT]) begin
            // merge into cur, keep its mark, then look at cur again
            mem_we    = 1'b1;
            mem_wdata = {merge_sum[WORD_W-1:3], 1'b0, hcur_q[HDR_MARK_BIT], 1'b0};
          end else begin
            cur_d = step_sum;
          end
        end
      end
      ST_RESP: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a heap size write rebuilds the list
    if (cfg_wr_en_i) begin
      used_d  = used_words_of(cfg_wr_data_i);
      state_d = ST_INIT_HDR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT_HDR;
      used_q       <= used_words_of(HEAP_BYTES_RST);
      steps_q      <= '0;
      res_status_q <= STATUS_DONE;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      steps_q      <= steps_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    nx_q       <= nx_d;
    hcur_q     <= hcur_d;
    need_q     <= need_d;
    res_addr_q <= res_addr_d;
  end

  assign ctl_o.in_stall        = (state_q != ST_IDLE) || cfg_wr_en_i;
  assign ctl_o.res_valid       = (state_q == ST_RESP);
  assign res_o.granted_address = res_addr_q;
  assign res_o.status          = res_status_q;

endmodule

`default_nettype wire

>>> rtl/ilha_checker.sv
// port-level checks of the heap allocator, bound to the top level
// depends on ilha_pkg and implicit_list_heap_allocator_assert.svh
`default_nettype none

`include "implicit_list_heap_allocator_assert.svh"

module ilha_checker
  import ilha_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire ilha_out_t out_o,
  input wire logic      cfg_wr_en_i
);

  // a taken request keeps the block busy
  `ILHA_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "no stall after request")

  // heap rebuild blocks requests
  `ILHA_ASSERT_NEXT(a_busy_after_cfg, cfg_wr_en_i, in_stall_o, "no stall after heap size write")

  // failed allocate reports offset zero
  `ILHA_ASSERT_IMPL(a_nofit_zero, out_valid_o && out_o.status, out_o.granted_address == '0, "no-fit result with nonzero address")

  // header offsets are word aligned
  `ILHA_ASSERT_IMPL(a_addr_aligned, out_valid_o, out_o.granted_address[1:0] == 2'b00, "unaligned granted address")

  `ILHA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_o), "stalled result changed")

endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (.*);

`default_nettype wire

>>> tb/tb_implicit_list_heap_allocator.sv
// self-checking testbench for the implicit-list first-fit heap allocator
// keeps a shadow copy of the heap and checks every result in order
// depends on ilha_pkg and the implicit_list_heap_allocator rtl
`timescale 1ns / 1ps

module tb_implicit_list_heap_allocator
  import ilha_pkg::*;
;

  localparam int unsigned        CYCLE_LIMIT  = 12_000_000;
  localparam int                 LONG_HOLD    = 400;
  localparam logic [FUNC_W-1:0]  FUNC_UNUSED  = FUNC_W'(3);
  localparam logic [WORD_W-1:0]  SIZE_BITS    = WORD_W'(13'h1FF8);
  localparam logic [WORD_W-1:0]  FLAG_BITS    =
    WORD_W'((1 << HDR_ALLOC_BIT) | (1 << HDR_MARK_BIT));

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PULSE} stall_mode_e;

  class heap_scoreboard;
    logic [WORD_W-1:0] shadow_heap [HEAP_WORDS];
    int                words_in_use;
    ilha_out_t         expected_results [$];
    logic [BYTE_W-1:0] live_blocks [$];
    int                errors;

    function new();
      errors = 0;
      rebuild(HEAP_BYTES_RST);
    endfunction

    function void rebuild(input logic [BYTE_W-1:0] heap_bytes);
      int total;
      int cap;
      total = (int'(heap_bytes) + 19) & ~7;
      cap   = (HEAP_WORDS * 4) & ~7;
      if (total > cap) begin
        total = cap;
      end
      foreach (shadow_heap[i]) begin
        shadow_heap[i] = '0;
      end
      words_in_use = total / 4;
      shadow_heap[1] = WORD_W'(total - 8);
      shadow_heap[words_in_use - 1] = '0;
      live_blocks.delete();
    endfunction

    // headers beyond the heap in use read as a sentinel
    function int size_at(input int idx);
      if (idx >= words_in_use) begin
        return 0;
      end
      return int'(shadow_heap[idx] & SIZE_BITS);
    endfunction

    function bit taken(input int idx);
      if (idx >= words_in_use) begin
        return 1'b0;
      end
      return shadow_heap[idx][HDR_ALLOC_BIT];
    endfunction

    function bit first_fit(input int length, output logic [BYTE_W-1:0] addr);
      int need;
      int cur;
      int sz;
      int rest;
      addr = '0;
      need = (length + 11) & ~7;
      cur  = 1;
      for (int steps = 0; steps < 2 * HEAP_WORDS; steps++) begin
        sz = size_at(cur);
        if (sz == 0) begin
          return 1'b0;
        end
        if (!taken(cur) && sz >= need) begin
          // an exact fit keeps the following header intact
          if (sz > need) begin
            rest = cur + need / 4;
            if (rest < words_in_use) begin
              shadow_heap[rest] = WORD_W'(sz - need);
            end
          end
          shadow_heap[cur] = WORD_W'(need | (1 << HDR_ALLOC_BIT));
          addr = BYTE_W'(cur * 4);
          return 1'b1;
        end
        cur = cur + sz / 4;
      end
      return 1'b0;
    endfunction

    function void merge_free_runs();
      int cur;
      int nx;
      cur = 1;
      for (int steps = 0; steps < 2 * HEAP_WORDS; steps++) begin
        if (size_at(cur) == 0) begin
          return;
        end
        nx = cur + size_at(cur) / 4;
        if (size_at(nx) == 0) begin
          return;
        end
        if (taken(cur)) begin
          cur = nx;
        end else if (!taken(nx)) begin
          // stay on cur so a whole run folds into one block
          shadow_heap[cur] = (WORD_W'(size_at(cur) + size_at(nx)) & SIZE_BITS) |
                             (shadow_heap[cur] & WORD_W'(1 << HDR_MARK_BIT));
        end else begin
          cur = nx + size_at(nx) / 4;
        end
      end
    endfunction

    function void release_word(input logic [BYTE_W-1:0] baddr);
      int w;
      w = int'(baddr) / 4;
      if (w < words_in_use) begin
        shadow_heap[w] = shadow_heap[w] & ~FLAG_BITS;
        for (int i = live_blocks.size() - 1; i >= 0; i--) begin
          if (int'(live_blocks[i]) / 4 == w) begin
            live_blocks.delete(i);
          end
        end
      end
    endfunction

    function void note_request(input ilha_in_t req);
      ilha_out_t         exp;
      logic [BYTE_W-1:0] addr;
      exp.granted_address = '0;
      exp.status          = STATUS_DONE;
      case (req.func)
        FUNC_ALLOC: begin
          if (first_fit(int'(req.request_length), addr)) begin
            exp.granted_address = addr;
            live_blocks.push_back(addr);
          end else begin
            exp.status = STATUS_NO_FIT;
          end
        end
        FUNC_FREE: begin
          release_word(req.block_address);
        end
        FUNC_COALESCE: begin
          merge_free_runs();
        end
        default: begin
        end
      endcase
      expected_results.push_back(exp);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(input ilha_out_t got);
      ilha_out_t exp;
      if (expected_results.size() == 0) begin
        report($sformatf("result with none expected: addr %0d status %0d",
                         got.granted_address, got.status));
      end else begin
        exp = expected_results.pop_front();
        if (got.granted_address !== exp.granted_address) begin
          report($sformatf("granted_address %0d, expected %0d",
                           got.granted_address, exp.granted_address));
        end
        if (got.status !== exp.status) begin
          report($sformatf("status %0d, expected %0d", got.status, exp.status));
        end
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  ilha_in_t          in_i;
  logic              out_valid_o;
  logic              out_stall_i;
  ilha_out_t         out_o;
  logic              cfg_wr_en_i;
  logic [BYTE_W-1:0] cfg_wr_data_i;

  heap_scoreboard sb;
  int unsigned    cycle_count = 0;
  int             holds_wanted = 0;

  implicit_list_heap_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_i          (in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_o         (out_o),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: stall modes of its own, plus long hold-offs on demand
  initial begin
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    int          holds_done;
    mode        = STALL_NONE;
    mode_left   = 0;
    hold_left   = 0;
    holds_done  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_o);
      end
      if (holds_done < holds_wanted) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= mode_left[2];
        endcase
      end
    end
  end

  task automatic send_req(input ilha_in_t req);
    in_valid_i <= 1'b1;
    in_i       <= req;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    sb.note_request(req);
  endtask

  task automatic issue(input logic [FUNC_W-1:0] func, input int length, input int addr);
    ilha_in_t req;
    req.func           = func;
    req.request_length = BYTE_W'(length);
    req.block_address  = BYTE_W'(addr);
    send_req(req);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_heap_size(input logic [BYTE_W-1:0] heap_bytes);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= heap_bytes;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    sb.rebuild(heap_bytes);
  endtask

  // mostly frees of live blocks and modest allocations, with some noise
  function automatic ilha_in_t make_request();
    ilha_in_t req;
    int       pick;
    int       span;
    req.func           = FUNC_W'($urandom_range(0, 3));
    req.request_length = BYTE_W'($urandom_range(0, 4095));
    req.block_address  = BYTE_W'($urandom_range(0, 4095));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      req.func = FUNC_ALLOC;
      span = $urandom_range(0, 99);
      if (span < 60) begin
        req.request_length = BYTE_W'($urandom_range(0, 60));
      end else if (span < 90) begin
        req.request_length = BYTE_W'($urandom_range(61, 500));
      end
    end else if (pick < 80) begin
      req.func = FUNC_FREE;
      if (sb.live_blocks.size() != 0 && $urandom_range(0, 99) < 85) begin
        req.block_address = sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)];
        if ($urandom_range(0, 4) == 0) begin
          req.block_address[1:0] = 2'($urandom_range(1, 3));
        end
      end
    end else if (pick < 95) begin
      req.func = FUNC_COALESCE;
    end else begin
      req.func = FUNC_UNUSED;
    end
    return req;
  endfunction

  task automatic run_random(input int count, input bit long_hold);
    int sent;
    int burst;
    int gap;
    bit drain;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        // sender keeps offering while the result side holds off
        if (long_hold && sent == count / 3) begin
          holds_wanted++;
        end
        send_req(make_request());
        sent++;
      end
      if (sent < count) begin
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        drain = ($urandom_range(0, 7) == 0);
        if (gap > 0 || drain) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
          if (drain) begin
            wait_drained();
          end
        end
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_i          = '0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full heap after reset: fits, misses, exact fits, splits and merges
    issue(FUNC_ALLOC, 4095, 0);
    issue(FUNC_ALLOC, 0, 4095);
    issue(FUNC_ALLOC, 4084, 0);
    issue(FUNC_ALLOC, 4076, 0);
    issue(FUNC_ALLOC, 1, 0);
    issue(FUNC_FREE, 0, 4);
    issue(FUNC_FREE, 4095, 15);
    issue(FUNC_COALESCE, 0, 0);
    issue(FUNC_ALLOC, 100, 0);
    issue(FUNC_ALLOC, 200, 0);
    issue(FUNC_ALLOC, 50, 0);
    issue(FUNC_FREE, 0, 108);
    issue(FUNC_COALESCE, 0, 0);
    issue(FUNC_FREE, 0, 316);
    issue(FUNC_COALESCE, 0, 0);
    issue(FUNC_FREE, 0, 2048);
    issue(FUNC_UNUSED, 4095, 4095);
    issue(FUNC_FREE, 0, 0);

    // smallest heap: one 8-byte block, frees past the end are dropped
    set_heap_size(BYTE_W'(1));
    issue(FUNC_ALLOC, 0, 0);
    issue(FUNC_ALLOC, 0, 0);
    issue(FUNC_FREE, 0, 4092);
    issue(FUNC_FREE, 0, 4);
    issue(FUNC_COALESCE, 0, 0);

    set_heap_size(BYTE_W'(4095));
    run_random(119, 1'b1);
    set_heap_size(BYTE_W'(4084));
    run_random(119, 1'b0);
    set_heap_size(BYTE_W'(64));
    run_random(119, 1'b0);
    set_heap_size(BYTE_W'(1000));
    run_random(119, 1'b0);
    set_heap_size(BYTE_W'($urandom_range(2000, 4095)));
    run_random(119, 1'b1);
    set_heap_size(BYTE_W'(200));
    run_random(119, 1'b0);
    set_heap_size(BYTE_W'($urandom_range(1, 4095)));
    run_random(119, 1'b0);
    set_heap_size(BYTE_W'(4084));
    run_random(119, 1'b0);

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
